// File: hdl/fldq_pkg.sv
// Shared constants, codes and controller/datapath interface types for the frame list manager.
`timescale 1ns / 1ps

package fldq_pkg;

    localparam int POOL_SLOTS = 16;
    localparam int SLOT_W     = $clog2(POOL_SLOTS);
    localparam int COUNT_W    = $clog2(POOL_SLOTS + 1);
    localparam int ORDER_W    = 32;
    localparam int MODE_W     = 3;

    // Stream packing.
    localparam int S_TDATA_W = ((SLOT_W + ORDER_W + 7) / 8) * 8;
    localparam int M_TDATA_W = ((SLOT_W + COUNT_W + 7) / 8) * 8;
    localparam int M_TUSER_W = 2;

    typedef enum logic [MODE_W-1:0] {
        MODE_PUSH_FRONT = 3'd0,
        MODE_PUSH_BACK  = 3'd1,
        MODE_POP_FRONT  = 3'd2,
        MODE_POP_BACK   = 3'd3,
        MODE_FIND_ORDER = 3'd4,
        MODE_REMOVE     = 3'd5,
        MODE_PEEK_FRONT = 3'd6,
        MODE_IGNORED    = 3'd7
    } mode_t;

    typedef enum logic [3:0] {
        DP_IDLE,
        DP_LOAD,
        DP_SET_ERR,
        DP_PUSH,
        DP_SEL_HEAD,
        DP_SEL_TAIL,
        DP_SEL_SLOT,
        DP_UNLINK_SHORT,
        DP_LINK_READ,
        DP_UNLINK,
        DP_FIND_INIT,
        DP_FIND_READ,
        DP_FIND_STEP,
        DP_EMIT
    } dp_op_t;

    typedef struct packed {
        dp_op_t op;
    } dp_cmd_t;

    typedef struct packed {
        mode_t mode;
        logic  mark_hit;
        logic  count_zero;
        logic  count_le1;
        logic  find_match;
        logic  find_end;
        logic  out_free;
    } dp_status_t;

endpackage

// File: hdl/frame_list_deque_manager.sv
// Top level of the frame list manager: stream ports, controller and datapath.
// Push, peek, ignored and rejected items go from decode to the done state, then to the result.
// Pop and remove of a last entry skip the link stores; else the links are read, then rewritten.
// Find reads and compares entries one by one from the head until one matches or the list ends.
// One item is in work at a time; the next is accepted once the result is in the output register.
// aresetn is synchronous and active low; it empties the list and clears membership marks.
`timescale 1ns / 1ps

module frame_list_deque_manager
    import fldq_pkg::*;
(
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 s_tvalid,
    output logic                 s_tready,
    input  logic [S_TDATA_W-1:0] s_tdata,   // slot [3:0], order_number [35:4]
    input  logic [MODE_W-1:0]    s_tuser,   // mode [2:0]
    output logic                 m_tvalid,
    input  logic                 m_tready,
    output logic [M_TDATA_W-1:0] m_tdata,   // result_slot [3:0], entry_count [8:4]
    output logic [M_TUSER_W-1:0] m_tuser    // error [0], found [1]
);

    dp_cmd_t    cmd;
    dp_status_t status;

    fldq_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .in_valid (s_tvalid),
        .in_ready (s_tready),
        .status   (status),
        .cmd      (cmd)
    );

    fldq_datapath u_datapath (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .cmd      (cmd),
        .status   (status),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser)
    );

endmodule

// File: hdl/fldq_ctrl.sv
// Controller state machine that sequences each list operation through the datapath.
`timescale 1ns / 1ps

module fldq_ctrl
    import fldq_pkg::*;
(
    input  logic       aclk,
    input  logic       aresetn,
    input  logic       in_valid,
    output logic       in_ready,
    input  dp_status_t status,
    output dp_cmd_t    cmd
);

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_DECODE,
        ST_UNLINK_CHK,
        ST_UNLINK_WR,
        ST_FIND_CHK,
        ST_FIND_CMP,
        ST_DONE
    } state_t;

    state_t state_reg, state_next;

    assign in_ready = (state_reg == ST_IDLE);

    always_comb begin
        state_next = state_reg;
        cmd.op     = DP_IDLE;
        unique case (state_reg)
            ST_IDLE: begin
                if (in_valid) begin
                    cmd.op     = DP_LOAD;
                    state_next = ST_DECODE;
                end
            end
            ST_DECODE: begin
                state_next = ST_DONE;
                unique case (status.mode)
                    MODE_PUSH_FRONT, MODE_PUSH_BACK: begin
                        cmd.op = status.mark_hit ? DP_SET_ERR : DP_PUSH;
                    end
                    MODE_POP_FRONT, MODE_POP_BACK: begin
                        if (status.count_zero) begin
                            cmd.op = DP_SET_ERR;
                        end else begin
                            cmd.op     = (status.mode == MODE_POP_BACK) ? DP_SEL_TAIL
                                                                        : DP_SEL_HEAD;
                            state_next = ST_UNLINK_CHK;
                        end
                    end
                    MODE_PEEK_FRONT: begin
                        cmd.op = status.count_zero ? DP_SET_ERR : DP_SEL_HEAD;
                    end
                    MODE_REMOVE: begin
                        if (!status.mark_hit) begin
                            cmd.op = DP_SET_ERR;
                        end else begin
                            cmd.op     = DP_SEL_SLOT;
                            state_next = ST_UNLINK_CHK;
                        end
                    end
                    MODE_FIND_ORDER: begin
                        cmd.op     = DP_FIND_INIT;
                        state_next = ST_FIND_CHK;
                    end
                    default: begin
                        cmd.op = DP_IDLE;
                    end
                endcase
            end
            ST_UNLINK_CHK: begin
                // A last entry leaves without touching the link stores.
                if (status.count_le1) begin
                    cmd.op     = DP_UNLINK_SHORT;
                    state_next = ST_DONE;
                end else begin
                    cmd.op     = DP_LINK_READ;
                    state_next = ST_UNLINK_WR;
                end
            end
            ST_UNLINK_WR: begin
                cmd.op     = DP_UNLINK;
                state_next = ST_DONE;
            end
            ST_FIND_CHK: begin
                if (status.find_end) begin
                    state_next = ST_DONE;
                end else begin
                    cmd.op     = DP_FIND_READ;
                    state_next = ST_FIND_CMP;
                end
            end
            ST_FIND_CMP: begin
                cmd.op     = DP_FIND_STEP;
                state_next = status.find_match ? ST_DONE : ST_FIND_CHK;
            end
            ST_DONE: begin
                if (status.out_free) begin
                    cmd.op     = DP_EMIT;
                    state_next = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

endmodule

// File: hdl/fldq_datapath.sv
// Datapath: link and order stores, membership marks, head/tail/count and the result register.
`timescale 1ns / 1ps

module fldq_datapath
    import fldq_pkg::*;
(
    input  logic                 aclk,
    input  logic                 aresetn,
    input  dp_cmd_t              cmd,
    output dp_status_t           status,
    input  logic [S_TDATA_W-1:0] s_tdata,
    input  logic [MODE_W-1:0]    s_tuser,
    output logic                 m_tvalid,
    input  logic                 m_tready,
    output logic [M_TDATA_W-1:0] m_tdata,
    output logic [M_TUSER_W-1:0] m_tuser
);

    logic [SLOT_W-1:0]  next_link_mem  [POOL_SLOTS];
    logic [SLOT_W-1:0]  prev_link_mem  [POOL_SLOTS];
    logic [ORDER_W-1:0] slot_order_mem [POOL_SLOTS];

    mode_t                 mode_reg, mode_next;
    logic [SLOT_W-1:0]     slot_reg, slot_next;
    logic [ORDER_W-1:0]    key_reg, key_next;
    logic [POOL_SLOTS-1:0] mark_reg, mark_next;
    logic [SLOT_W-1:0]     head_reg, head_next;
    logic [SLOT_W-1:0]     tail_reg, tail_next;
    logic [COUNT_W-1:0]    count_reg, count_next;
    logic [SLOT_W-1:0]     target_reg, target_next;
    logic [SLOT_W-1:0]     cur_reg, cur_next;
    logic [COUNT_W-1:0]    idx_reg, idx_next;
    logic                  err_reg, err_next;
    logic                  found_reg, found_next;
    logic [SLOT_W-1:0]     res_reg, res_next;
    logic                  out_valid_reg, out_valid_next;
    logic [M_TDATA_W-1:0]  out_data_reg, out_data_next;
    logic [M_TUSER_W-1:0]  out_user_reg, out_user_next;

    logic [SLOT_W-1:0]  next_rd_reg;
    logic [SLOT_W-1:0]  prev_rd_reg;
    logic [ORDER_W-1:0] order_rd_reg;
    logic [SLOT_W-1:0]  rd_addr;

    logic               next_we, prev_we, order_we;
    logic [SLOT_W-1:0]  next_wa, prev_wa;
    logic [SLOT_W-1:0]  next_wd, prev_wd;

    logic               is_head, is_tail;

    assign is_head = (target_reg == head_reg);
    assign is_tail = (target_reg == tail_reg);
    assign rd_addr = (cmd.op == DP_FIND_READ) ? cur_reg : target_reg;

    assign status.mode       = mode_reg;
    assign status.mark_hit   = mark_reg[slot_reg];
    assign status.count_zero = (count_reg == '0);
    assign status.count_le1  = (count_reg <= COUNT_W'(1));
    assign status.find_match = (order_rd_reg == key_reg);
    assign status.find_end   = (idx_reg == count_reg);
    assign status.out_free   = !out_valid_reg || m_tready;

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_data_reg;
    assign m_tuser  = out_user_reg;

    always_comb begin
        mode_next      = mode_reg;
        slot_next      = slot_reg;
        key_next       = key_reg;
        mark_next      = mark_reg;
        head_next      = head_reg;
        tail_next      = tail_reg;
        count_next     = count_reg;
        target_next    = target_reg;
        cur_next       = cur_reg;
        idx_next       = idx_reg;
        err_next       = err_reg;
        found_next     = found_reg;
        res_next       = res_reg;
        out_valid_next = out_valid_reg && !m_tready;
        out_data_next  = out_data_reg;
        out_user_next  = out_user_reg;
        case (cmd.op)
            DP_LOAD: begin
                mode_next  = mode_t'(s_tuser);
                slot_next  = s_tdata[SLOT_W-1:0];
                key_next   = s_tdata[SLOT_W+ORDER_W-1:SLOT_W];
                err_next   = 1'b0;
                found_next = 1'b0;
                res_next   = '0;
            end
            DP_SET_ERR: begin
                err_next = 1'b1;
            end
            DP_PUSH: begin
                mark_next[slot_reg] = 1'b1;
                count_next          = count_reg + COUNT_W'(1);
                if (count_reg == '0) begin
                    head_next = slot_reg;
                    tail_next = slot_reg;
                end else if (mode_reg == MODE_PUSH_FRONT) begin
                    head_next = slot_reg;
                end else begin
                    tail_next = slot_reg;
                end
            end
            DP_SEL_HEAD: begin
                target_next = head_reg;
                res_next    = head_reg;
                found_next  = 1'b1;
            end
            DP_SEL_TAIL: begin
                target_next = tail_reg;
                res_next    = tail_reg;
                found_next  = 1'b1;
            end
            DP_SEL_SLOT: begin
                target_next = slot_reg;
            end
            DP_UNLINK_SHORT: begin
                mark_next[target_reg] = 1'b0;
                head_next             = '0;
                tail_next             = '0;
                count_next            = '0;
            end
            DP_UNLINK: begin
                mark_next[target_reg] = 1'b0;
                count_next            = count_reg - COUNT_W'(1);
                if (is_head) begin
                    head_next = next_rd_reg;
                end
                if (is_tail) begin
                    tail_next = prev_rd_reg;
                end
            end
            DP_FIND_INIT: begin
                cur_next = head_reg;
                idx_next = '0;
            end
            DP_FIND_STEP: begin
                if (order_rd_reg == key_reg) begin
                    found_next = 1'b1;
                    res_next   = cur_reg;
                end else begin
                    cur_next = next_rd_reg;
                    idx_next = idx_reg + COUNT_W'(1);
                end
            end
            DP_EMIT: begin
                out_valid_next = 1'b1;
                out_data_next  = M_TDATA_W'({count_reg, res_reg});
                out_user_next  = {found_reg, err_reg};
            end
            default: begin
            end
        endcase
    end

    // Link store writes: each store takes at most one write per operation step.
    always_comb begin
        next_we  = 1'b0;
        prev_we  = 1'b0;
        next_wa  = slot_reg;
        prev_wa  = slot_reg;
        next_wd  = head_reg;
        prev_wd  = tail_reg;
        order_we = (cmd.op == DP_PUSH);
        case (cmd.op)
            DP_PUSH: begin
                if (count_reg != '0) begin
                    next_we = 1'b1;
                    prev_we = 1'b1;
                    if (mode_reg == MODE_PUSH_FRONT) begin
                        next_wa = slot_reg;
                        next_wd = head_reg;
                        prev_wa = head_reg;
                        prev_wd = slot_reg;
                    end else begin
                        prev_wa = slot_reg;
                        prev_wd = tail_reg;
                        next_wa = tail_reg;
                        next_wd = slot_reg;
                    end
                end
            end
            DP_UNLINK: begin
                next_we = !is_head;
                next_wa = prev_rd_reg;
                next_wd = next_rd_reg;
                prev_we = !is_tail;
                prev_wa = next_rd_reg;
                prev_wd = prev_rd_reg;
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (next_we) begin
            next_link_mem[next_wa] <= next_wd;
        end
        if (prev_we) begin
            prev_link_mem[prev_wa] <= prev_wd;
        end
        if (order_we) begin
            slot_order_mem[slot_reg] <= key_reg;
        end
        next_rd_reg  <= next_link_mem[rd_addr];
        prev_rd_reg  <= prev_link_mem[rd_addr];
        order_rd_reg <= slot_order_mem[cur_reg];
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            mark_reg      <= '0;
            head_reg      <= '0;
            tail_reg      <= '0;
            count_reg     <= '0;
            out_valid_reg <= 1'b0;
        end else begin
            mark_reg      <= mark_next;
            head_reg      <= head_next;
            tail_reg      <= tail_next;
            count_reg     <= count_next;
            out_valid_reg <= out_valid_next;
        end
        mode_reg     <= mode_next;
        slot_reg     <= slot_next;
        key_reg      <= key_next;
        target_reg   <= target_next;
        cur_reg      <= cur_next;
        idx_reg      <= idx_next;
        err_reg      <= err_next;
        found_reg    <= found_next;
        res_reg      <= res_next;
        out_data_reg <= out_data_next;
        out_user_reg <= out_user_next;
    end

`ifndef SYNTHESIS
    a_count_matches_marks: assert property (@(posedge aclk) disable iff (!aresetn)
        $countones(mark_reg) == 32'(count_reg))
        else $error("list count disagrees with membership marks");

    a_empty_ends_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        (count_reg == '0) |-> (head_reg == '0 && tail_reg == '0))
        else $error("empty list with nonzero head or tail");

    a_ends_listed: assert property (@(posedge aclk) disable iff (!aresetn)
        (count_reg != '0) |-> (mark_reg[head_reg] && mark_reg[tail_reg]))
        else $error("head or tail slot not marked as listed");

    a_find_bounded: assert property (@(posedge aclk) disable iff (!aresetn)
        (cmd.op == DP_FIND_READ) |-> (idx_reg < count_reg))
        else $error("find walked past the end of the list");
`endif

endmodule

// File: verif/frame_list_deque_manager_test.sv
// Self-checking testbench for the frame list deque manager: directed table, then random list traffic.
`timescale 1ns / 1ps

module frame_list_deque_manager_test;
    import fldq_pkg::*;

    localparam int RANDOM_ITEMS = 1450;
    localparam int STALL_LIMIT  = 4000;
    localparam int DRAIN_CYCLES = 60;
    localparam int HOLD_AT      = 400;
    localparam int HOLD_CYCLES  = 400;

    typedef struct packed {
        logic               error;
        logic               found;
        logic [SLOT_W-1:0]  slot;
        logic [COUNT_W-1:0] count;
    } list_result_t;

    typedef struct {
        mode_t              mode;
        logic [SLOT_W-1:0]  slot;
        logic [ORDER_W-1:0] order;
        bit                 typed;
        list_result_t       want;
    } plan_row_t;

    logic                 aclk     = 1'b0;
    logic                 aresetn  = 1'b0;
    logic                 s_tvalid = 1'b0;
    logic                 s_tready;
    logic [S_TDATA_W-1:0] s_tdata  = '0;
    logic [MODE_W-1:0]    s_tuser  = '0;
    logic                 m_tvalid;
    logic                 m_tready = 1'b0;
    logic [M_TDATA_W-1:0] m_tdata;   // result_slot [3:0], entry_count [8:4]
    logic [M_TUSER_W-1:0] m_tuser;   // error [0], found [1]

    // Shadow copy of the list, updated as each item is accepted.
    logic [SLOT_W-1:0]  fwd_link  [POOL_SLOTS];
    logic [SLOT_W-1:0]  back_link [POOL_SLOTS];
    logic [ORDER_W-1:0] pic_order [POOL_SLOTS];
    bit                 in_list   [POOL_SLOTS];
    logic [SLOT_W-1:0]  front_slot = '0;
    logic [SLOT_W-1:0]  rear_slot  = '0;
    logic [COUNT_W-1:0] used_count = '0;

    list_result_t expected_results[$];
    plan_row_t    plan[$];
    int           fails = 0;
    bit           steady_tx = 1'b0;

    frame_list_deque_manager u_top (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser)
    );

    always #5 aclk = ~aclk;

    function automatic void detach_slot(logic [SLOT_W-1:0] s);
        logic [SLOT_W-1:0] n;
        logic [SLOT_W-1:0] p;
        bit                at_front;
        bit                at_rear;
        if (used_count <= 1) begin
            front_slot = '0;
            rear_slot  = '0;
            used_count = '0;
        end else begin
            n        = fwd_link[s];
            p        = back_link[s];
            at_front = (s == front_slot);
            at_rear  = (s == rear_slot);
            if (at_front) front_slot = n;
            if (at_rear) rear_slot = p;
            if (!at_front) fwd_link[p] = n;
            if (!at_rear) back_link[n] = p;
            used_count = used_count - 1'b1;
        end
        in_list[s]   = 1'b0;
        fwd_link[s]  = '0;
        back_link[s] = '0;
    endfunction

    function automatic list_result_t apply_list_op(mode_t mode, logic [SLOT_W-1:0] slot,
                                                   logic [ORDER_W-1:0] key);
        list_result_t      r;
        logic [SLOT_W-1:0] cur;
        r = '0;
        case (mode) inside
            MODE_PUSH_FRONT, MODE_PUSH_BACK: begin
                if (in_list[slot]) begin
                    r.error = 1'b1;
                end else begin
                    pic_order[slot] = key;
                    in_list[slot]   = 1'b1;
                    if (used_count == 0) begin
                        fwd_link[slot]  = '0;
                        back_link[slot] = '0;
                        front_slot      = slot;
                        rear_slot       = slot;
                    end else if (mode == MODE_PUSH_FRONT) begin
                        fwd_link[slot]        = front_slot;
                        back_link[slot]       = '0;
                        back_link[front_slot] = slot;
                        front_slot            = slot;
                    end else begin
                        back_link[slot]     = rear_slot;
                        fwd_link[slot]      = '0;
                        fwd_link[rear_slot] = slot;
                        rear_slot           = slot;
                    end
                    used_count = used_count + 1'b1;
                end
            end
            MODE_POP_FRONT, MODE_POP_BACK, MODE_PEEK_FRONT: begin
                if (used_count == 0) begin
                    r.error = 1'b1;
                end else begin
                    r.slot  = (mode == MODE_POP_BACK) ? rear_slot : front_slot;
                    r.found = 1'b1;
                    if (mode != MODE_PEEK_FRONT) detach_slot(r.slot);
                end
            end
            MODE_FIND_ORDER: begin
                cur = front_slot;
                for (int i = 0; i < used_count && i < POOL_SLOTS; i++) begin
                    if (pic_order[cur] == key) begin
                        r.found = 1'b1;
                        r.slot  = cur;
                        break;
                    end
                    cur = fwd_link[cur];
                end
            end
            MODE_REMOVE: begin
                if (!in_list[slot]) r.error = 1'b1;
                else detach_slot(slot);
            end
            default: ;
        endcase
        r.count = used_count;
        return r;
    endfunction

    function automatic void add_row(mode_t mode, logic [SLOT_W-1:0] slot,
                                    logic [ORDER_W-1:0] order, bit typed,
                                    logic err, logic fnd, logic [SLOT_W-1:0] rs,
                                    logic [COUNT_W-1:0] cnt);
        plan_row_t row;
        row.mode  = mode;
        row.slot  = slot;
        row.order = order;
        row.typed = typed;
        row.want  = '{error: err, found: fnd, slot: rs, count: cnt};
        plan.push_back(row);
    endfunction

    // Starting at a random slot, return the first one whose membership matches.
    function automatic logic [SLOT_W-1:0] pick_slot(bit want_listed);
        int start;
        start = $urandom_range(POOL_SLOTS - 1);
        for (int k = 0; k < POOL_SLOTS; k++) begin
            if (in_list[(start + k) % POOL_SLOTS] == want_listed)
                return SLOT_W'((start + k) % POOL_SLOTS);
        end
        return SLOT_W'(start);
    endfunction

    // Small keys and extremes make duplicate order numbers likely, so find sees several hits.
    function automatic logic [ORDER_W-1:0] pick_order();
        int r;
        r = $urandom_range(99);
        if (r < 65) return $urandom;
        if (r < 85) return ORDER_W'($urandom_range(7));
        case ($urandom_range(3))
            0:       return 32'h8000_0000;
            1:       return 32'h7fff_ffff;
            2:       return 32'hffff_ffff;
            default: return 32'h0000_0000;
        endcase
    endfunction

    task automatic send_item(mode_t mode, logic [SLOT_W-1:0] slot, logic [ORDER_W-1:0] order,
                             bit typed, list_result_t want);
        list_result_t got;
        while (!steady_tx && $urandom_range(99) < 24) begin
            s_tvalid <= 1'b0;
            @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= S_TDATA_W'({order, slot});
        s_tuser  <= mode;
        @(posedge aclk);
        while (!s_tready) @(posedge aclk);
        got = apply_list_op(mode, slot, order);
        expected_results.push_back(typed ? want : got);
    endtask

    // Result checker.
    always @(posedge aclk) begin
        list_result_t want;
        if (aresetn && m_tvalid && m_tready) begin
            if (expected_results.size() == 0) begin
                $error("result item with nothing expected: tdata %h tuser %b", m_tdata, m_tuser);
                fails++;
            end else begin
                want = expected_results.pop_front();
                if (m_tuser[0] !== want.error) begin
                    $error("error: expected %0d, got %0d", want.error, m_tuser[0]);
                    fails++;
                end
                if (m_tuser[1] !== want.found) begin
                    $error("found: expected %0d, got %0d", want.found, m_tuser[1]);
                    fails++;
                end
                if (m_tdata[SLOT_W-1:0] !== want.slot) begin
                    $error("result_slot: expected %0d, got %0d", want.slot, m_tdata[SLOT_W-1:0]);
                    fails++;
                end
                if (m_tdata[SLOT_W +: COUNT_W] !== want.count) begin
                    $error("entry_count: expected %0d, got %0d", want.count,
                           m_tdata[SLOT_W +: COUNT_W]);
                    fails++;
                end
            end
        end
    end

    // Receiver: random stalls, one long hold-off, and a stretch with no stalls.
    initial begin
        int rx_count;
        int hold_left;
        bit held;
        rx_count  = 0;
        hold_left = 0;
        held      = 1'b0;
        forever begin
            @(posedge aclk);
            if (m_tvalid && m_tready) rx_count++;
            if (!held && rx_count == HOLD_AT) begin
                held      = 1'b1;
                hold_left = HOLD_CYCLES;
            end
            if (hold_left > 0) begin
                hold_left--;
                m_tready <= 1'b0;
            end else if (rx_count >= 700 && rx_count < 900) begin
                m_tready <= 1'b1;
            end else begin
                m_tready <= ($urandom_range(99) >= 24);
            end
        end
    end

    initial begin
        int quiet;
        quiet = 0;
        while (quiet < STALL_LIMIT) begin
            @(posedge aclk);
            if (!aresetn || (s_tvalid && s_tready) || (m_tvalid && m_tready)) quiet = 0;
            else quiet++;
        end
        $display("Some tests failed");
        $finish;
    end

    initial begin
        mode_t              mode;
        logic [SLOT_W-1:0]  slot;
        logic [ORDER_W-1:0] order;
        int                 useful;
        int                 fill_goal;
        int                 r;

        for (int i = 0; i < POOL_SLOTS; i++) begin
            fwd_link[i]  = '0;
            back_link[i] = '0;
            pic_order[i] = '0;
            in_list[i]   = 1'b0;
        end

        // Empty list after reset.
        add_row(MODE_POP_FRONT,  4'd0,  32'd0,        1, 1, 0, 0, 0);
        add_row(MODE_POP_BACK,   4'd15, 32'd0,        1, 1, 0, 0, 0);
        add_row(MODE_PEEK_FRONT, 4'd0,  32'd0,        1, 1, 0, 0, 0);
        add_row(MODE_REMOVE,     4'd0,  32'd0,        1, 1, 0, 0, 0);
        add_row(MODE_FIND_ORDER, 4'd0,  32'd0,        1, 0, 0, 0, 0);
        add_row(MODE_IGNORED,    4'd15, 32'hffffffff, 1, 0, 0, 0, 0);
        // Extreme slots and order numbers, then duplicate pushes.
        add_row(MODE_PUSH_FRONT, 4'd15, 32'h7fffffff, 1, 0, 0, 0, 1);
        add_row(MODE_PUSH_BACK,  4'd0,  32'h80000000, 1, 0, 0, 0, 2);
        add_row(MODE_PUSH_FRONT, 4'd15, 32'd1,        1, 1, 0, 0, 2);
        add_row(MODE_PUSH_BACK,  4'd0,  32'd2,        1, 1, 0, 0, 2);
        add_row(MODE_PUSH_BACK,  4'd5,  32'hffffffff, 0, 0, 0, 0, 0);
        add_row(MODE_FIND_ORDER, 4'd0,  32'h80000000, 0, 0, 0, 0, 0);
        add_row(MODE_FIND_ORDER, 4'd0,  32'd12345,    0, 0, 0, 0, 0);
        add_row(MODE_PEEK_FRONT, 4'd0,  32'd0,        0, 0, 0, 0, 0);
        // Remove from the middle, then remove the same slot again.
        add_row(MODE_REMOVE,     4'd0,  32'd0,        0, 0, 0, 0, 0);
        add_row(MODE_REMOVE,     4'd0,  32'd0,        1, 1, 0, 0, 2);
        add_row(MODE_IGNORED,    4'd3,  32'd7,        0, 0, 0, 0, 0);
        add_row(MODE_POP_BACK,   4'd0,  32'd0,        0, 0, 0, 0, 0);
        add_row(MODE_POP_FRONT,  4'd0,  32'd0,        0, 0, 0, 0, 0);
        // Remove of the only entry empties the list.
        add_row(MODE_PUSH_FRONT, 4'd10, 32'd0,        0, 0, 0, 0, 0);
        add_row(MODE_REMOVE,     4'd10, 32'd0,        0, 0, 0, 0, 0);
        add_row(MODE_POP_FRONT,  4'd0,  32'd0,        1, 1, 0, 0, 0);

        repeat (9) @(posedge aclk);
        aresetn <= 1'b1;

        foreach (plan[i]) send_item(plan[i].mode, plan[i].slot, plan[i].order,
                                    plan[i].typed, plan[i].want);

        useful    = 0;
        fill_goal = POOL_SLOTS;
        while (useful < RANDOM_ITEMS) begin
            if (useful % 40 == 0) begin
                r = $urandom_range(3);
                fill_goal = (r == 0) ? 0 : (r == 1) ? POOL_SLOTS : $urandom_range(POOL_SLOTS);
            end
            steady_tx = (useful >= 700 && useful < 900);
            slot  = SLOT_W'($urandom);
            order = $urandom;
            r     = $urandom_range(99);
            if (r < 2) begin
                mode = MODE_IGNORED;
            end else if (r < 7) begin
                mode = mode_t'($urandom_range(7));
            end else begin
                r = $urandom_range(99);
                if (used_count < fill_goal) begin
                    mode = (r < 55) ? (r[0] ? MODE_PUSH_FRONT : MODE_PUSH_BACK) :
                           (r < 72) ? MODE_FIND_ORDER :
                           (r < 80) ? MODE_PEEK_FRONT :
                           (r < 88) ? MODE_REMOVE :
                           (r[0] ? MODE_POP_FRONT : MODE_POP_BACK);
                end else begin
                    mode = (r < 15) ? (r[0] ? MODE_PUSH_FRONT : MODE_PUSH_BACK) :
                           (r < 40) ? MODE_FIND_ORDER :
                           (r < 50) ? MODE_PEEK_FRONT :
                           (r < 70) ? MODE_REMOVE :
                           (r[0] ? MODE_POP_FRONT : MODE_POP_BACK);
                end
                case (mode) inside
                    MODE_PUSH_FRONT, MODE_PUSH_BACK: begin
                        if ($urandom_range(9) != 0) slot = pick_slot(1'b0);
                        order = pick_order();
                    end
                    MODE_FIND_ORDER: begin
                        if (used_count != 0 && $urandom_range(9) < 7)
                            order = pic_order[pick_slot(1'b1)];
                        else
                            order = pick_order();
                    end
                    MODE_REMOVE: begin
                        if ($urandom_range(9) < 8) slot = pick_slot(1'b1);
                    end
                    default: ;
                endcase
            end
            send_item(mode, slot, order, 1'b0, '0);
            if (mode != MODE_IGNORED) useful++;
        end
        steady_tx = 1'b0;
        s_tvalid <= 1'b0;

        while (expected_results.size() != 0) @(posedge aclk);
        repeat (DRAIN_CYCLES) @(posedge aclk);

        if (fails == 0 && expected_results.size() == 0) begin
            $display("All tests passed");
        end else begin
            $display("Some tests failed");
        end
        $finish;
    end

endmodule

// File: filelist.f
hdl/fldq_pkg.sv
hdl/fldq_ctrl.sv
hdl/fldq_datapath.sv
hdl/frame_list_deque_manager.sv
verif/frame_list_deque_manager_test.sv
